FILE: sv/qpht_pkg.sv
// Package for the quadratic-probing hash table unit: slot flags, result
// status codes, the entry layout and the fixed field widths.
// It has no dependencies; the top level imports it.
package qpht_pkg;

    localparam int KEY_W      = 31;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 8;
    localparam int OCC_W      = 9;
    localparam int TSIZE_W    = 9;
    localparam int OCC_MAX    = 511;
    localparam int TSIZE_RST  = 256;

    // Input word packing: key in the low bits, value above it, zero padded.
    localparam int IN_DATA_W  = 64;
    // Output word packing: status, slot index, occupied count, zero padded.
    localparam int OUT_DATA_W = 24;

    // Remainder unit: key bits consumed per cycle, and the padded key width.
    localparam int DIV_DIGIT  = 4;
    localparam int KEY_PAD_W  = ((KEY_W + DIV_DIGIT - 1) / DIV_DIGIT) * DIV_DIGIT;
    localparam int DIV_STEPS  = KEY_PAD_W / DIV_DIGIT;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        FLAG_EMPTY   = 2'd0,
        FLAG_USED    = 2'd1,
        FLAG_DELETED = 2'd2
    } flag_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_BLOCKED   = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_NOT_FOUND = 3'd5
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef struct packed {
        flag_t             flag;
        logic [KEY_W-1:0]  key;
    } entry_t;

endpackage

FILE: sv/quadratic_probe_hash_table_unit.sv
// Quadratic-probing key/value hash table with an entry memory (flag and key)
// and a value memory, both synchronous; the entry memory's read port is registered.
// Depends on qpht_pkg for codes, the entry layout and field widths.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: key, value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, slot_index, occupied_count
// config    in   table_size_we                table_size_wdata: table_size
//
// A word passes through these steps in order: acceptance, remainder steps at four key
// bits each, the issue of the first read, one check per probe (the probe count runs
// from 1 to the active size) and the load of the output register.
// After reset every slot of the entry memory is swept clear; a table_size write
// recounts the occupied slots inside the active size. tready is low meanwhile.
// A result waits in the output register; a later one stalls until that is free.
module quadratic_probe_hash_table_unit
    import qpht_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [30:0] key, [62:31] value, [63] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] status, [10:3] slot_index, [19:11] occupied_count, [23:20] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  table_size_we,
    input  logic [TSIZE_W-1:0]    table_size_wdata
);

    // Address width of the memories, width of a size or count, extended widths.
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int EW  = SW + 1;
    localparam int CW  = (SW > TSIZE_W) ? SW : TSIZE_W;
    localparam int XW  = (SW > OCC_W) ? SW : OCC_W;
    localparam int RESET_SIZE = (CAPACITY < TSIZE_RST) ? CAPACITY : TSIZE_RST;

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_RECOUNT = 7'b0000100,
        S_DIV     = 7'b0001000,
        S_PROBE   = 7'b0010000,
        S_CHECK   = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    // Memories.
    entry_t             ent_mem [CAPACITY];
    logic [VALUE_W-1:0] val_mem [CAPACITY];
    entry_t             rd_data_reg;

    // Control registers.
    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SW-1:0]         size_reg, size_next;
    logic [SW-1:0]         cnt_reg, cnt_next;
    logic [SW-1:0]         sweep_reg, sweep_next;
    logic                  pend_reg, pend_next;

    // Datapath registers.
    func_t                 func_reg, func_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [KEY_PAD_W-1:0]  shift_reg, shift_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SW-1:0]         rem_reg, rem_next;
    logic [AW-1:0]         h_reg, h_next;
    logic [AW-1:0]         d_reg, d_next;
    logic [SW-1:0]         attempt_reg, attempt_next;
    status_t               res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Memory port controls.
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    entry_t                wr_data;
    logic                  val_we;

    // Clamped table size for a configuration write: zero acts as one, and
    // anything above CAPACITY acts as CAPACITY.
    logic [CW-1:0]         cfg_ext;
    logic [SW-1:0]         cfg_size;

    always_comb
    begin
        cfg_ext = CW'(table_size_wdata);
        if (table_size_wdata == '0)
        begin
            cfg_size = SW'(1);
        end
        else if (cfg_ext > CW'(CAPACITY))
        begin
            cfg_size = SW'(CAPACITY);
        end
        else
        begin
            cfg_size = cfg_ext[SW-1:0];
        end
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        logic [SW-1:0]     rem_w;
        logic [SW:0]       rem_t;
        logic [EW-1:0]     hs;
        logic [EW-1:0]     ds;
        logic              last_probe;
        logic              key_hit;
        logic              done;
        logic [XW-1:0]     cnt_ext;
        logic [OCC_W-1:0]  occ;

        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        size_next       = table_size_we ? cfg_size : size_reg;
        cnt_next        = cnt_reg;
        sweep_next      = sweep_reg;
        pend_next       = 1'b0;
        func_next       = func_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        shift_next      = shift_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        h_next          = h_reg;
        d_next          = d_reg;
        attempt_next    = attempt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_data_next   = out_data_reg;

        rd_en   = 1'b0;
        rd_addr = h_reg;
        wr_en   = 1'b0;
        wr_addr = h_reg;
        wr_data = '{flag: FLAG_USED, key: key_reg};
        val_we  = 1'b0;

        // Four bits of the remainder per cycle, restoring style.
        rem_w = rem_reg;
        for (int j = 0; j < DIV_DIGIT; j++)
        begin
            rem_t = {rem_w, shift_reg[KEY_PAD_W-1-j]};
            if (rem_t >= {1'b0, size_reg})
            begin
                rem_t = rem_t - {1'b0, size_reg};
            end
            rem_w = rem_t[SW-1:0];
        end

        // Next probe: h + d, then d + 2, each reduced by the active size.
        hs = EW'(h_reg) + EW'(d_reg);
        if (hs >= EW'(size_reg))
        begin
            hs = hs - EW'(size_reg);
        end
        ds = EW'(d_reg) + EW'(2);
        if (ds >= EW'(size_reg))
        begin
            ds = ds - EW'(size_reg);
        end
        if (ds >= EW'(size_reg))
        begin
            ds = ds - EW'(size_reg);
        end

        // Occupied count as reported, saturated to the field width.
        cnt_ext = XW'(cnt_reg);
        if (cnt_ext > XW'(OCC_MAX))
        begin
            cnt_ext = XW'(OCC_MAX);
        end
        occ = cnt_ext[OCC_W-1:0];

        last_probe = (attempt_reg == size_reg - SW'(1));
        key_hit    = (rd_data_reg.flag == FLAG_USED) && (rd_data_reg.key == key_reg);
        done       = 1'b0;

        // The output register empties when its word is taken.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg[AW-1:0];
                wr_data    = '{flag: FLAG_EMPTY, key: '0};
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == SW'(CAPACITY - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (table_size_we)
                begin
                    sweep_next = '0;
                    cnt_next   = '0;
                    state_next = S_RECOUNT;
                end
                else if (s_axis_tvalid)
                begin
                    func_next  = func_t'(s_axis_tuser);
                    key_next   = s_axis_tdata[KEY_W-1:0];
                    value_next = s_axis_tdata[KEY_W +: VALUE_W];
                    shift_next = KEY_PAD_W'(s_axis_tdata[KEY_W-1:0]);
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end

            S_RECOUNT:
            begin
                if (table_size_we)
                begin
                    // A further size write starts the sweep over.
                    sweep_next = '0;
                    cnt_next   = '0;
                end
                else
                begin
                    if (sweep_reg < size_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = sweep_reg[AW-1:0];
                        sweep_next = sweep_reg + SW'(1);
                        pend_next  = 1'b1;
                    end
                    if (pend_reg && (rd_data_reg.flag == FLAG_USED))
                    begin
                        cnt_next = cnt_reg + SW'(1);
                    end
                    if (!(sweep_reg < size_reg) && !pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DIV:
            begin
                rem_next   = rem_w;
                shift_next = shift_reg << DIV_DIGIT;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // Probe zero sits at key mod size; the first stride is 1 mod size.
                h_next       = rem_reg[AW-1:0];
                d_next       = (size_reg == SW'(1)) ? '0 : AW'(1);
                attempt_next = '0;
                rd_en        = 1'b1;
                rd_addr      = rem_reg[AW-1:0];
                state_next   = S_CHECK;
            end

            S_CHECK:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (rd_data_reg.flag == FLAG_EMPTY)
                    begin
                        wr_en           = 1'b1;
                        val_we          = 1'b1;
                        cnt_next        = cnt_reg + SW'(1);
                        res_status_next = STAT_INSERTED;
                        res_slot_next   = SLOT_W'(h_reg);
                        done            = 1'b1;
                    end
                    else if (key_hit)
                    begin
                        val_we          = 1'b1;
                        res_status_next = STAT_UPDATED;
                        res_slot_next   = SLOT_W'(h_reg);
                        done            = 1'b1;
                    end
                    else if (rd_data_reg.flag == FLAG_DELETED)
                    begin
                        res_status_next = STAT_BLOCKED;
                        res_slot_next   = '0;
                        done            = 1'b1;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = STAT_FULL;
                        res_slot_next   = '0;
                        done            = 1'b1;
                    end
                end
                else
                begin
                    if (key_hit)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = '{flag: FLAG_DELETED, key: key_reg};
                        cnt_next        = cnt_reg - SW'(1);
                        res_status_next = STAT_REMOVED;
                        res_slot_next   = SLOT_W'(h_reg);
                        done            = 1'b1;
                    end
                    else if ((rd_data_reg.flag == FLAG_EMPTY) || last_probe)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                        res_slot_next   = '0;
                        done            = 1'b1;
                    end
                end

                if (done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    h_next       = hs[AW-1:0];
                    d_next       = ds[AW-1:0];
                    attempt_next = attempt_reg + SW'(1);
                    rd_en        = 1'b1;
                    rd_addr      = hs[AW-1:0];
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = OUT_DATA_W'({occ, res_slot_reg, res_status_reg});
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ent_mem[rd_addr];
        end
    end

    // Value memory: written on insert and update.
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[wr_addr] <= value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            size_reg      <= SW'(RESET_SIZE);
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            size_reg      <= size_next;
            cnt_reg       <= cnt_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        shift_reg      <= shift_next;
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        h_reg          <= h_next;
        d_reg          <= d_next;
        attempt_reg    <= attempt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_data_reg   <= out_data_next;
    end

    // A size write in the same cycle as an input word takes priority.
    assign s_axis_tready = (state_reg == S_IDLE) && !table_size_we;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The occupied count never exceeds the active table size while the unit is idle.
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg <= size_reg))
        else $error("occupied count exceeds active table size");

    // Probe position and stride stay reduced below the active size.
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ((SW'(h_reg) < size_reg) && (SW'(d_reg) < size_reg)))
        else $error("probe address or stride out of range");

    // A result that leaves the emit state is visible on the output next cycle.
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready)) |=> m_axis_tvalid)
        else $error("result not loaded into output register");

    // The probe counter never runs past the active size.
    a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (attempt_reg < size_reg))
        else $error("probe count exceeds active table size");

endmodule

FILE: test/qpht_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the quadratic-probing hash table unit: it mirrors the slot
// flags, keys and table size, predicts each result word and compares it.
// Depends on qpht_pkg for the status, flag and function codes and widths.
module qpht_checker
    import qpht_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  table_size_we,
    input  logic [TSIZE_W-1:0]    table_size_wdata,

    output int                    mismatches,
    output int                    outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occupied;
    } probe_outcome_t;

    flag_t              flag_mem [CAPACITY];
    logic [KEY_W-1:0]   key_mem  [CAPACITY];
    logic [TSIZE_W-1:0] size_reg;
    probe_outcome_t     predicted_results [$];

    // Applies one insert or remove to the mirrored table and returns the
    // result word that the unit should produce for it.
    function automatic probe_outcome_t run_table_op(func_t fn, logic [KEY_W-1:0] key);
        probe_outcome_t res;
        int unsigned    span;
        int unsigned    attempt;
        int unsigned    s;
        int unsigned    used;
        bit             done;

        span = (size_reg == 0) ? 1 : ((size_reg > CAPACITY) ? CAPACITY : size_reg);
        res.slot = '0;
        done = 1'b0;
        attempt = 0;
        if (fn == FUNC_INSERT)
        begin
            res.status = STAT_FULL;
            while (!done && attempt < span)
            begin
                // Key plus square stays below 2**32, so 32-bit math is exact.
                s = (32'(key) + attempt * attempt) % span;
                if (flag_mem[s] == FLAG_EMPTY)
                begin
                    flag_mem[s] = FLAG_USED;
                    key_mem[s] = key;
                    res.status = STAT_INSERTED;
                    res.slot = s[SLOT_W-1:0];
                    done = 1'b1;
                end
                else if (flag_mem[s] == FLAG_USED && key_mem[s] == key)
                begin
                    res.status = STAT_UPDATED;
                    res.slot = s[SLOT_W-1:0];
                    done = 1'b1;
                end
                else if (flag_mem[s] == FLAG_DELETED)
                begin
                    res.status = STAT_BLOCKED;
                    done = 1'b1;
                end
                attempt++;
            end
        end
        else
        begin
            res.status = STAT_NOT_FOUND;
            while (!done)
            begin
                s = (32'(key) + attempt * attempt) % span;
                if (flag_mem[s] == FLAG_USED && key_mem[s] == key)
                begin
                    flag_mem[s] = FLAG_DELETED;
                    res.status = STAT_REMOVED;
                    res.slot = s[SLOT_W-1:0];
                    done = 1'b1;
                end
                else
                begin
                    attempt++;
                    if (flag_mem[s] == FLAG_EMPTY || attempt >= span)
                        done = 1'b1;
                end
            end
        end

        // Only slots inside the active size are counted.
        used = 0;
        for (attempt = 0; attempt < span; attempt++)
            if (flag_mem[attempt] == FLAG_USED)
                used++;
        res.occupied = (used > OCC_MAX) ? OCC_W'(OCC_MAX) : used[OCC_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        probe_outcome_t got;
        probe_outcome_t want;
        int             idx;

        if (!rst_n)
        begin
            for (idx = 0; idx < CAPACITY; idx++)
                flag_mem[idx] = FLAG_EMPTY;
            size_reg = TSIZE_W'(TSIZE_RST);
            predicted_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status   = status_t'(m_axis_tdata[STATUS_W-1:0]);
                got.slot     = m_axis_tdata[STATUS_W +: SLOT_W];
                got.occupied = m_axis_tdata[STATUS_W+SLOT_W +: OCC_W];
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result word status %0d slot %0d occupied %0d",
                                 $realtime, got.status, got.slot, got.occupied);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.occupied !== want.occupied)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: result mismatch, expected status %0d slot %0d ",
                                      "occupied %0d, got status %0d slot %0d occupied %0d"},
                                     $realtime, want.status, want.slot, want.occupied,
                                     got.status, got.slot, got.occupied);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                predicted_results.push_back(
                    run_table_op(func_t'(s_axis_tuser), s_axis_tdata[KEY_W-1:0]));

            // Writes only happen while the unit is idle, so ordering is moot.
            if (table_size_we)
                size_reg = table_size_wdata;

            outstanding = predicted_results.size();
        end
    end

endmodule

FILE: test/quadratic_probe_hash_table_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the quadratic-probing hash table unit: drives insert and
// remove words over several table sizes and gives the verdict.
// Depends on qpht_pkg, the unit itself and the qpht_checker scoreboard.
module quadratic_probe_hash_table_unit_tb;
    import qpht_pkg::*;

    localparam int TABLE_CAP       = 256;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int IDLE_PCT        = 23;
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 128;
    localparam int POOL_SIZE       = 24;
    localparam int POOL_PCT        = 85;
    localparam int REMOVE_PCT      = 30;
    // Word counts that bound the stretch in which neither side idles.
    localparam int STEADY_FROM     = 700;
    localparam int STEADY_TO       = 950;
    // The result side stops taking words for a long while once this many
    // input words have gone in, so the unit fills up and backs up its input.
    localparam int HOLD_OFF_AT     = 250;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 30;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  table_size_we;
    logic [TSIZE_W-1:0]    table_size_wdata;

    int   mismatches;
    int   outstanding;
    int   sent_words = 0;
    int   cycle_count = 0;
    logic steady_stretch;

    // Sizes for the random phases, mostly rising so that larger tables still
    // have fresh slots after the small ones have left deleted marks behind.
    // 511 is beyond the capacity and acts as a full-size table.
    int   phase_sizes [PHASES] = '{1, 2, 5, 8, 13, 32, 61, 128, 200, 511, 257, 256};

    assign steady_stretch = (sent_words >= STEADY_FROM) && (sent_words < STEADY_TO);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    quadratic_probe_hash_table_unit #(
        .CAPACITY         (TABLE_CAP)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .table_size_we    (table_size_we),
        .table_size_wdata (table_size_wdata)
    );

    qpht_checker #(
        .CAPACITY         (TABLE_CAP)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .table_size_we    (table_size_we),
        .table_size_wdata (table_size_wdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // Offers one word after a random number of idle cycles and returns at the
    // clock edge where it is accepted. The ready is sampled on the falling
    // edge, where nothing is changing, to decide whether the next rising
    // edge completes the handshake.
    task automatic offer_word(func_t fn, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val);
        bit taken;

        while (!steady_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {1'b0, val, key};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        sent_words++;
    endtask

    // Drops the valid and waits until every predicted result has come back
    // and the unit is ready for new words again (no sweep in progress).
    task automatic wait_drained();
        bit idle;

        s_axis_tvalid <= 1'b0;
        idle = 1'b0;
        while (!idle)
        begin
            @(negedge clk);
            idle = (outstanding == 0) && s_axis_tready;
            @(posedge clk);
        end
    endtask

    // The size register is only written while the unit is idle.
    task automatic write_table_size(logic [TSIZE_W-1:0] size);
        wait_drained();
        table_size_we    <= 1'b1;
        table_size_wdata <= size;
        @(posedge clk);
        table_size_we    <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off, and no stalls at all
    // during the steady stretch.
    initial
    begin : result_sink
        bit held_off;

        held_off = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && sent_words >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            m_axis_tready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        func_t            fn;
        int               span;
        int               phase;
        int               n;
        int               j;

        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        table_size_we    = 1'b0;
        table_size_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A size of zero behaves as a single-slot table.
        write_table_size(TSIZE_W'(0));
        offer_word(FUNC_INSERT, 31'd3, 32'h8000_0000);          // fills slot 0
        offer_word(FUNC_INSERT, 31'd5, 32'h7FFF_FFFF);          // only slot holds 3: full
        offer_word(FUNC_INSERT, 31'd3, 32'hFFFF_FFFF);          // same key: update
        offer_word(FUNC_REMOVE, 31'd9, 32'h0000_0000);          // one probe, not found

        // Full size, from the register's reset value written explicitly.
        write_table_size(TSIZE_W'(TSIZE_RST));
        offer_word(FUNC_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);  // top slot
        offer_word(FUNC_INSERT, 31'd0, 32'h8000_0000);          // slot 0 taken, goes to 1
        offer_word(FUNC_INSERT, 31'd0, 32'h1234_5678);          // update at slot 1
        offer_word(FUNC_REMOVE, 31'h7FFF_FFFF, 32'hFFFF_FFFF);  // top slot deleted
        offer_word(FUNC_REMOVE, 31'h7FFF_FFFF, 32'h0000_0000);  // walks past it, not found
        offer_word(FUNC_INSERT, 31'h7FFF_FFFF, 32'h5555_5555);  // stops on the deleted slot
        offer_word(FUNC_INSERT, 31'd511, 32'hAAAA_AAAA);        // other key, same blocked slot
        // Key 3 went in under the single-slot size; at full size it hashes to
        // an empty slot, so it is no longer found.
        offer_word(FUNC_REMOVE, 31'd3, 32'h0000_0000);
        offer_word(FUNC_REMOVE, 31'd0, 32'h0000_0000);          // found on the second probe
        offer_word(FUNC_INSERT, 31'd0, 32'h0F0F_0F0F);          // blocked by that deletion
        offer_word(FUNC_INSERT, 31'h5555_5555, 32'hF0F0_F0F0);

        // Random phases: most keys come from a small pool so that updates,
        // removes, collisions and full or blocked probes happen often; the
        // rest are arbitrary keys that exercise every key bit.
        for (phase = 0; phase < PHASES; phase++)
        begin
            span = (phase_sizes[phase] > TABLE_CAP) ? TABLE_CAP : phase_sizes[phase];
            write_table_size(TSIZE_W'(phase_sizes[phase]));
            for (j = 0; j < POOL_SIZE; j++)
                key_pool[j] = (j % 2 == 0) ? KEY_W'($urandom())
                                           : KEY_W'($urandom_range(3 * span, 0));
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                key = ($urandom_range(99) < POOL_PCT) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                      : KEY_W'($urandom());
                fn  = ($urandom_range(99) < REMOVE_PCT) ? FUNC_REMOVE : FUNC_INSERT;
                offer_word(fn, key, $urandom());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
sv/qpht_pkg.sv
sv/quadratic_probe_hash_table_unit.sv
test/qpht_checker.sv
test/quadratic_probe_hash_table_unit_tb.sv
